>>> hw/rtl/fcrc_pkg.sv
// Shared types and constants for the free chunk reuse cache.
// Used by fcrc_cell and free_chunk_reuse_cache; depends on nothing.
package fcrc_pkg;

  localparam int SLOTS  = 8;
  localparam int LEN_W  = 32;
  localparam int OFF_W  = 64;
  localparam int DENS_W = 7;
  localparam int PROD_W = LEN_W + DENS_W;

  localparam logic [DENS_W-1:0] FILL_SCALE    = 7'd100;
  localparam logic [DENS_W-1:0] DENSITY_RESET = 7'd75;

  localparam logic OP_FREE  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } fcrc_state_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] off;
  } fcrc_slot_t;

  // Travels from the top slot toward slot 0.
  typedef struct packed {
    logic taken;
    logic shift;
  } fcrc_down_t;

  // Travels from slot 0 toward the top slot.
  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] off;
  } fcrc_up_t;

endpackage

>>> hw/rtl/free_chunk_reuse_cache.sv
// Top level of the free chunk reuse cache: item registers, control and the
// chain of slot cells. Depends on fcrc_pkg and fcrc_cell.
//
// An item on the in_ channel either records a freed chunk (operation 0) or
// requests an allocation (operation 1). Every item produces exactly one item
// on the out_ channel: stored for a free, hit and reuse_offset for an
// allocate. Both channels use valid/ready.
// An item is handled in order: the accept edge loads the item register, and
// in the evaluate state (ST_EVAL) all slot cells are evaluated at once, the
// table is updated and the output register is loaded. A new item is accepted
// only in ST_IDLE, after the previous item has been evaluated, so the block
// does not take a new item before it is through with the last one.
// If the receiver stalls with a result still held, the evaluate step waits
// and the table is not updated until the output register is free.
// The cfg_ port writes the density threshold in percent at any edge where
// cfg_wr_en is high; it must only be written while the block is idle.
// Synchronous reset empties every slot, sets the threshold to 75 and drops
// any pending result.
module free_chunk_reuse_cache
  import fcrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [DENS_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [OFF_W-1:0]  in_chunk_offset,
  input  logic [LEN_W-1:0]  in_chunk_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [OFF_W-1:0]  out_reuse_offset,
  output logic              out_stored
);

  fcrc_state_t       state_r, state_nxt;
  logic [DENS_W-1:0] density_r;
  logic              op_r;
  logic [OFF_W-1:0]  off_r;
  logic [LEN_W-1:0]  len_r;
  logic [PROD_W-1:0] len_scaled_r;
  logic              out_valid_r, out_valid_nxt;
  logic              hit_r;
  logic [OFF_W-1:0]  reuse_off_r;
  logic              stored_r;
  logic              accept;
  logic              apply;
  logic              alloc_ok;

  fcrc_slot_t slots [SLOTS+1];
  fcrc_down_t dn    [SLOTS+1];
  fcrc_up_t   up    [SLOTS+1];

  assign accept   = in_valid && in_ready;
  assign alloc_ok = (len_r != '0) && (slots[SLOTS-1].len != '0);

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    apply         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!out_valid_r || out_ready) begin
          apply         = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      density_r   <= DENSITY_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        density_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_operation;
      off_r        <= in_chunk_offset;
      len_r        <= in_chunk_length;
      len_scaled_r <= {{DENS_W{1'b0}}, in_chunk_length} * {{LEN_W{1'b0}}, FILL_SCALE};
    end
    if (apply) begin
      hit_r       <= (op_r == OP_ALLOC) && up[SLOTS].found;
      reuse_off_r <= (op_r == OP_ALLOC) ? up[SLOTS].off : '0;
      stored_r    <= (op_r == OP_FREE) && dn[0].taken;
    end
  end

  assign slots[SLOTS] = '0;
  assign dn[SLOTS]    = '0;
  assign up[0]        = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    fcrc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .apply      (apply),
      .op         (op_r),
      .len        (len_r),
      .off        (off_r),
      .len_scaled (len_scaled_r),
      .density    (density_r),
      .alloc_ok   (alloc_ok),
      .upper      (slots[i+1]),
      .dn_in      (dn[i+1]),
      .dn_out     (dn[i]),
      .up_in      (up[i]),
      .up_out     (up[i+1]),
      .slot       (slots[i])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_reuse_offset = reuse_off_r;
  assign out_stored       = stored_r;

  a_hit_excludes_stored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(hit_r && stored_r))
    else $error("hit and stored both set on one item");

  a_miss_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !hit_r) |-> (reuse_off_r == '0))
    else $error("nonzero offset on a miss");

  a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EVAL))
    else $error("result appeared without an evaluate step");

  a_accept_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EVAL) && !in_ready)
    else $error("accepted item not followed by evaluate step");

endmodule

>>> hw/rtl/fcrc_cell.sv
// One slot of the chunk table: holds a length and an offset and decides its
// part of a free or allocate item. Depends on fcrc_pkg.
module fcrc_cell
  import fcrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              apply,
  input  logic              op,
  input  logic [LEN_W-1:0]  len,
  input  logic [OFF_W-1:0]  off,
  input  logic [PROD_W-1:0] len_scaled,
  input  logic [DENS_W-1:0] density,
  input  logic              alloc_ok,
  input  fcrc_slot_t        upper,
  input  fcrc_down_t        dn_in,
  output fcrc_down_t        dn_out,
  input  fcrc_up_t          up_in,
  output fcrc_up_t          up_out,
  output fcrc_slot_t        slot
);

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [PROD_W-1:0] need;
  logic              occupied;
  logic              free_cand;
  logic              alloc_cand;
  logic              sel_free;
  logic              sel_alloc;

  assign occupied   = (len_r != '0);
  assign free_cand  = (len > len_r);
  assign need       = {{DENS_W{1'b0}}, len_r} * {{LEN_W{1'b0}}, density};
  assign alloc_cand = alloc_ok && occupied && (len <= len_r) && (len_scaled >= need);
  assign sel_free   = (op == OP_FREE) && free_cand && !dn_in.taken;
  assign sel_alloc  = (op == OP_ALLOC) && alloc_cand && !up_in.found;

  assign dn_out.taken = dn_in.taken | free_cand;
  assign dn_out.shift = dn_in.shift | (sel_free & occupied);
  assign up_out.found = up_in.found | alloc_cand;
  assign up_out.off   = up_in.off | (sel_alloc ? off_r : '0);
  assign slot.len     = len_r;
  assign slot.off     = off_r;

  always_comb begin
    len_nxt = len_r;
    off_nxt = off_r;
    if (apply) begin
      if (sel_free) begin
        len_nxt = len;
        off_nxt = off;
      end else if ((op == OP_FREE) && dn_in.shift) begin
        len_nxt = upper.len;
        off_nxt = upper.off;
      end else if (sel_alloc) begin
        len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
  end

endmodule
